FILE: design/hsfc_pkg.sv
package hsfc_pkg;

    // Frame kind carried in req_type
    typedef enum logic {
        KIND_TEMP = 1'b0,
        KIND_HUMI = 1'b1
    } frame_kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_CRC     = 2'd1,
        STATUS_NO_TEMP = 2'd2
    } status_t;

    typedef struct packed {
        frame_kind_t req_type;
        logic [7:0]  data_high;
        logic [7:0]  data_low;
        logic [7:0]  check_byte;
    } in_item_t;

    typedef struct packed {
        logic signed [14:0] value;
        status_t            status;
    } out_item_t;

    // Update of the held temperature, from the converter to the state registers
    typedef struct packed {
        logic               load_temp;
        logic               clear_present;
        logic signed [14:0] temp;
    } hold_upd_t;

    localparam logic [7:0]  CRC_POLY     = 8'h31;
    localparam logic [15:0] TEMP_SCALE   = 16'd17572;
    localparam logic [15:0] TEMP_OFFSET  = 16'd4685;
    localparam logic [15:0] HUM_SCALE    = 16'd12500;
    localparam logic [15:0] HUM_OFFSET   = 16'd600;
    localparam logic [15:0] HUM_REF_TEMP = 16'd2500;
    // 15/100 reduces to 3/20; floor(x/20) = (x * 52429) >> 20 for x < 262144
    localparam logic [15:0] DIV20_RECIP  = 16'd52429;
    localparam int          DIV20_SHIFT  = 20;

    // CRC-8, MSB first, no reflection, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: design/hsfc_convert.sv
module hsfc_convert (
    input  hsfc_pkg::in_item_t         frame,
    input  logic signed [14:0]         held_temp,
    input  logic                       temp_present,
    output hsfc_pkg::out_item_t        result,
    output hsfc_pkg::hold_upd_t        upd
);

    logic [15:0]        raw;
    logic               crc_ok;
    logic [30:0]        temp_prod;
    logic signed [15:0] temp_val;
    logic [29:0]        hum_prod;
    logic signed [16:0] diff;
    logic signed [16:0] n3;
    logic               n3_neg;
    logic [16:0]        n3_abs;
    logic [31:0]        q_prod;
    logic [10:0]        q_abs;
    logic signed [15:0] q_term;
    logic signed [15:0] hum_val;

    assign raw    = {frame.data_high, frame.data_low};
    assign crc_ok = hsfc_pkg::crc8_byte(hsfc_pkg::crc8_byte(8'h00, frame.data_high),
                                        frame.data_low) == frame.check_byte;

    // Temperature: floor(17572*raw/65536) - 4685
    assign temp_prod = 31'(raw) * 31'(hsfc_pkg::TEMP_SCALE);
    assign temp_val  = signed'({1'b0, temp_prod[30:16]})
                     - signed'(hsfc_pkg::TEMP_OFFSET);

    // Humidity base: floor(12500*raw/65536) - 600
    assign hum_prod = 30'(raw) * 30'(hsfc_pkg::HUM_SCALE);

    // Correction -(3*(2500-T))/20, truncated toward zero, from the held register
    assign diff   = signed'({1'b0, hsfc_pkg::HUM_REF_TEMP}) - 17'(held_temp);
    assign n3     = (diff <<< 1) + diff;
    assign n3_neg = n3[16];
    assign n3_abs = n3_neg ? 17'(-n3) : 17'(n3);
    assign q_prod = 32'(n3_abs) * 32'(hsfc_pkg::DIV20_RECIP);
    assign q_abs  = q_prod[hsfc_pkg::DIV20_SHIFT +: 11];
    assign q_term = n3_neg ? signed'({5'b0, q_abs}) : -signed'({5'b0, q_abs});

    assign hum_val = signed'({2'b0, hum_prod[29:16]})
                   - signed'(hsfc_pkg::HUM_OFFSET) + q_term;

    always_comb begin
        result.value       = '0;
        result.status      = hsfc_pkg::STATUS_OK;
        upd.load_temp      = 1'b0;
        upd.clear_present  = 1'b0;
        upd.temp           = temp_val[14:0];
        if (frame.req_type == hsfc_pkg::KIND_TEMP) begin
            if (crc_ok) begin
                result.value  = temp_val[14:0];
                upd.load_temp = 1'b1;
            end else begin
                result.status = hsfc_pkg::STATUS_CRC;
            end
        end else if (!temp_present) begin
            result.status = hsfc_pkg::STATUS_NO_TEMP;
        end else begin
            // humidity always consumes the held temperature
            upd.clear_present = 1'b1;
            if (crc_ok) begin
                result.value = hum_val[14:0];
            end else begin
                result.status = hsfc_pkg::STATUS_CRC;
            end
        end
    end

endmodule

FILE: design/humidity_sensor_frame_converter.sv
// Channel  Direction  Payload                                       Handshake
// s_       in         req_type, data_high, data_low, check_byte     s_valid / s_ready
// m_       out        value (signed 15), status (2)                 m_valid / m_ready
//
// One frame per cycle sustained while m_ready is held high; each frame passes
// the input register, then the result register after the CRC and conversion
// logic, before m_valid rises for it. aresetn (synchronous, active low) empties
// both registers and drops the held temperature. A stall on m_ blocks s_ only
// once both registers are full.
module humidity_sensor_frame_converter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hsfc_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output hsfc_pkg::out_item_t m_item
);

    logic                in_valid_reg;
    hsfc_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    hsfc_pkg::out_item_t out_item_reg;
    logic signed [14:0]  held_temp_reg;
    logic                temp_present_reg;

    hsfc_pkg::out_item_t result;
    hsfc_pkg::hold_upd_t upd;
    logic                advance;

    hsfc_convert u_convert (
        .frame        (in_item_reg),
        .held_temp    (held_temp_reg),
        .temp_present (temp_present_reg),
        .result       (result),
        .upd          (upd)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            held_temp_reg    <= '0;
            temp_present_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                if (upd.load_temp) begin
                    held_temp_reg    <= upd.temp;
                    temp_present_reg <= 1'b1;
                end else if (upd.clear_present) begin
                    temp_present_reg <= 1'b0;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: load on transfer, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_item_reg.status != hsfc_pkg::STATUS_OK
            |-> out_item_reg.value == '0)
        else $error("error result carries a nonzero value");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.req_type == hsfc_pkg::KIND_HUMI |=> !temp_present_reg)
        else $error("humidity frame left a temperature held");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.req_type == hsfc_pkg::KIND_TEMP
            && result.status == hsfc_pkg::STATUS_OK
            |=> temp_present_reg && held_temp_reg == out_item_reg.value)
        else $error("good temperature not held");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("stalled input register lost its frame");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result.status == hsfc_pkg::STATUS_NO_TEMP |-> !temp_present_reg)
        else $error("no-temperature status while a temperature is held");

endmodule
